// ===== rtl/smi_pkg.sv =====
// shared constants, types and codes for the binary stl mesh indexer
`default_nettype none
package smi_pkg;

  localparam int VTX_CAP = 256;
  localparam int VTX_AW  = $clog2(VTX_CAP);
  localparam int VTX_CW  = $clog2(VTX_CAP + 1);
  localparam int WORD_W  = 96;
  localparam int POS_W   = 7;
  localparam int FACES_W = 32;

  localparam int HEADER_BYTES = 80;
  localparam int COUNT_BYTES  = 4;
  localparam int FACE_BYTES   = 50;

  // byte offsets within a face where a result may be due or the attribute begins, and section ends
  localparam logic [POS_W-1:0] POS_NORMAL = POS_W'(11);
  localparam logic [POS_W-1:0] POS_VTX0   = POS_W'(23);
  localparam logic [POS_W-1:0] POS_VTX1   = POS_W'(35);
  localparam logic [POS_W-1:0] POS_VTX2   = POS_W'(47);
  localparam logic [POS_W-1:0] POS_ATTR   = POS_W'(48);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FACE_BYTES - 1);
  localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_CNT_END = POS_W'(COUNT_BYTES - 1);

  typedef enum logic [1:0] {
    KIND_NORMAL  = 2'd0,
    KIND_VERTEX  = 2'd1,
    KIND_DROPPED = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_COUNT  = 4'b0010,
    PH_FACES  = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    SR_IDLE = 2'b01,
    SR_SCAN = 2'b10
  } srch_state_t;

  typedef struct packed {
    logic  emit;
    kind_t kind;
  } direct_t;

  typedef struct packed {
    logic start;
    logic clear;
  } srch_req_t;

  typedef struct packed {
    logic              done;
    kind_t             kind;
    logic [VTX_AW-1:0] index;
    logic              is_new;
    logic [VTX_CW-1:0] count;
  } srch_res_t;

endpackage
`default_nettype wire

// ===== rtl/smi_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none
module smi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/smi_parse.sv =====
// byte parser: header skip, face count, face layout and vertex assembly
`default_nettype none
module smi_parse (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           xfer,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           start_of_file,
  output      logic                           may_emit,
  output      smi_pkg::direct_t               direct,
  output      smi_pkg::srch_req_t             req,
  output      logic [smi_pkg::WORD_W-1:0]     word_next
);

  smi_pkg::phase_t                   phase, phase_next;
  logic [smi_pkg::POS_W-1:0]         pos, pos_next;
  logic [smi_pkg::FACES_W-1:0]       faces, faces_next;
  logic [smi_pkg::WORD_W-1:0]        word;

  smi_pkg::phase_t                   eph;
  logic [smi_pkg::POS_W-1:0]         epos;

  // conservative: a byte at one of these places may need the output slot
  assign may_emit = (phase == smi_pkg::PH_COUNT && pos == smi_pkg::POS_CNT_END) ||
                    (phase == smi_pkg::PH_FACES &&
                     (pos == smi_pkg::POS_NORMAL || pos == smi_pkg::POS_VTX0 ||
                      pos == smi_pkg::POS_VTX1 || pos == smi_pkg::POS_VTX2 ||
                      pos == smi_pkg::POS_LAST));

  always_comb begin
    eph        = start_of_file ? smi_pkg::PH_HEADER : phase;
    epos       = start_of_file ? '0 : pos;
    phase_next = eph;
    pos_next   = epos;
    faces_next = start_of_file ? '0 : faces;
    word_next  = word;
    direct     = '{emit: 1'b0, kind: smi_pkg::KIND_NORMAL};
    req        = '{start: 1'b0, clear: start_of_file};
    unique case (eph)
      smi_pkg::PH_HEADER: begin
        if (epos == smi_pkg::POS_HDR_END) begin
          pos_next   = '0;
          phase_next = smi_pkg::PH_COUNT;
          faces_next = '0;
        end else begin
          pos_next = epos + 1'b1;
        end
      end
      smi_pkg::PH_COUNT: begin
        // little-endian: bytes shift in from the top
        faces_next = {data_byte, faces[smi_pkg::FACES_W-1:8]};
        if (epos == smi_pkg::POS_CNT_END) begin
          pos_next = '0;
          if (faces_next == '0) begin
            phase_next  = smi_pkg::PH_DONE;
            direct.emit = 1'b1;
            direct.kind = smi_pkg::KIND_DONE;
          end else begin
            phase_next = smi_pkg::PH_FACES;
          end
        end else begin
          pos_next = epos + 1'b1;
        end
      end
      smi_pkg::PH_FACES: begin
        // twelve bytes of a triple shift in, so x lands in the low word
        if (epos < smi_pkg::POS_ATTR) begin
          word_next = {data_byte, word[smi_pkg::WORD_W-1:8]};
        end
        if (epos == smi_pkg::POS_NORMAL) begin
          direct.emit = 1'b1;
          direct.kind = smi_pkg::KIND_NORMAL;
        end
        if (epos == smi_pkg::POS_VTX0 || epos == smi_pkg::POS_VTX1 ||
            epos == smi_pkg::POS_VTX2) begin
          req.start = 1'b1;
        end
        if (epos == smi_pkg::POS_LAST) begin
          pos_next   = '0;
          faces_next = faces - 1'b1;
          if (faces == smi_pkg::FACES_W'(1)) begin
            phase_next  = smi_pkg::PH_DONE;
            direct.emit = 1'b1;
            direct.kind = smi_pkg::KIND_DONE;
          end
        end else begin
          pos_next = epos + 1'b1;
        end
      end
      smi_pkg::PH_DONE: begin
        phase_next = smi_pkg::PH_DONE;
      end
      default: begin
        phase_next = smi_pkg::PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= smi_pkg::PH_HEADER;
      pos   <= '0;
      faces <= '0;
    end else if (xfer) begin
      phase <= phase_next;
      pos   <= pos_next;
      faces <= faces_next;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      word <= word_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/smi_search.sv =====
// vertex deduplication: linear scan of the table memory, append on miss while room remains
`default_nettype none
module smi_search (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           xfer,
  input  wire smi_pkg::srch_req_t             req,
  input  wire logic [smi_pkg::WORD_W-1:0]     word,
  output      logic                           busy,
  output      logic [smi_pkg::VTX_CW-1:0]     stored,
  output      logic [smi_pkg::WORD_W-1:0]     vkey,
  output      smi_pkg::srch_res_t             res
);

  smi_pkg::srch_state_t              state, state_next;
  logic [smi_pkg::VTX_AW-1:0]        ridx, ridx_next;
  logic [smi_pkg::VTX_CW-1:0]        stored_next;
  logic [smi_pkg::WORD_W-1:0]        key;
  logic                              miss;
  logic                              we;
  logic                              re;
  logic [smi_pkg::VTX_AW-1:0]        raddr;
  logic [smi_pkg::WORD_W-1:0]        rdata;

  smi_ram #(
    .WIDTH (smi_pkg::WORD_W),
    .DEPTH (smi_pkg::VTX_CAP)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (stored[smi_pkg::VTX_AW-1:0]),
    .wdata (vkey),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy = (state == smi_pkg::SR_SCAN);
  // the new vertex is still on the parser side in the cycle it arrives
  assign vkey = (state == smi_pkg::SR_IDLE) ? word : key;

  always_comb begin
    state_next  = state;
    ridx_next   = ridx;
    stored_next = stored;
    miss        = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = ridx + 1'b1;
    res         = '{done: 1'b0, kind: smi_pkg::KIND_VERTEX, index: '0,
                    is_new: 1'b0, count: stored};
    unique case (state)
      smi_pkg::SR_IDLE: begin
        if (xfer && req.clear) begin
          stored_next = '0;
        end
        if (xfer && req.start) begin
          if (stored == '0) begin
            miss = 1'b1;
          end else begin
            re         = 1'b1;
            raddr      = '0;
            ridx_next  = '0;
            state_next = smi_pkg::SR_SCAN;
          end
        end
      end
      smi_pkg::SR_SCAN: begin
        // rdata holds entry ridx; the next read is issued alongside
        if (rdata == key) begin
          res.done   = 1'b1;
          res.index  = ridx;
          state_next = smi_pkg::SR_IDLE;
        end else if (smi_pkg::VTX_CW'(ridx) + 1'b1 == stored) begin
          miss       = 1'b1;
          state_next = smi_pkg::SR_IDLE;
        end else begin
          re        = 1'b1;
          ridx_next = ridx + 1'b1;
        end
      end
      default: begin
        state_next = smi_pkg::SR_IDLE;
      end
    endcase

    if (miss) begin
      res.done = 1'b1;
      if (stored == smi_pkg::VTX_CW'(smi_pkg::VTX_CAP)) begin
        res.kind = smi_pkg::KIND_DROPPED;
      end else begin
        we          = 1'b1;
        stored_next = stored + 1'b1;
        res.index   = stored[smi_pkg::VTX_AW-1:0];
        res.is_new  = 1'b1;
        res.count   = stored + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= smi_pkg::SR_IDLE;
      stored <= '0;
    end else begin
      state  <= state_next;
      stored <= stored_next;
    end
  end

  always_ff @(posedge clk) begin
    ridx <= ridx_next;
    if (state == smi_pkg::SR_IDLE && xfer && req.start) begin
      key <= word;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/stl_binary_mesh_indexer_top.sv =====
// top level: byte transfer handshake, parser, vertex search and result register
// one byte per cycle unless a scan or a full result slot holds the input; a normal
// or completion result is valid the cycle after its transfer. the last byte of a vertex
// holds the input while the table is scanned, one entry a cycle; a match, a new or a
// dropped vertex is registered when the scan ends (the cycle after, with an empty table)
// reset or a byte flagged start_of_file empties the table and restarts at header byte zero
`default_nettype none
module stl_binary_mesh_indexer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output      logic        byte_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_of_file,
  output      logic        result_valid,
  input  wire logic        result_ready,
  output      logic [1:0]  kind,
  output      logic [31:0] coord_x,
  output      logic [31:0] coord_y,
  output      logic [31:0] coord_z,
  output      logic [7:0]  vertex_index,
  output      logic        is_new,
  output      logic [8:0]  vertex_count
);

  logic                           xfer;
  logic                           may_emit;
  smi_pkg::direct_t               direct;
  smi_pkg::srch_req_t             req;
  logic [smi_pkg::WORD_W-1:0]     word_next;
  logic                           busy;
  logic [smi_pkg::VTX_CW-1:0]     stored;
  logic [smi_pkg::WORD_W-1:0]     vkey;
  smi_pkg::srch_res_t             res;
  logic                           load_direct;

  assign byte_ready  = !busy && (!may_emit || !result_valid || result_ready);
  assign xfer        = byte_valid && byte_ready;
  assign load_direct = xfer && direct.emit;

  smi_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .xfer          (xfer),
    .data_byte     (data_byte),
    .start_of_file (start_of_file),
    .may_emit      (may_emit),
    .direct        (direct),
    .req           (req),
    .word_next     (word_next)
  );

  smi_search u_search (
    .clk    (clk),
    .rst    (rst),
    .xfer   (xfer),
    .req    (req),
    .word   (word_next),
    .busy   (busy),
    .stored (stored),
    .vkey   (vkey),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res.done || load_direct) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      kind         <= res.kind;
      coord_x      <= vkey[31:0];
      coord_y      <= vkey[63:32];
      coord_z      <= vkey[95:64];
      vertex_index <= 8'(res.index);
      is_new       <= res.is_new;
      vertex_count <= 9'(res.count);
    end else if (load_direct) begin
      kind         <= direct.kind;
      vertex_index <= '0;
      is_new       <= 1'b0;
      vertex_count <= 9'(stored);
      if (direct.kind == smi_pkg::KIND_DONE) begin
        coord_x <= '0;
        coord_y <= '0;
        coord_z <= '0;
      end else begin
        coord_x <= word_next[31:0];
        coord_y <= word_next[63:32];
        coord_z <= word_next[95:64];
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/stl_binary_mesh_indexer_top_tb.sv =====
// self-checking testbench for the binary stl mesh indexer top level
`timescale 1ns / 1ps
`default_nettype none
module stl_binary_mesh_indexer_top_tb;

  typedef struct packed {
    smi_pkg::kind_t kind;
    logic [31:0]    x;
    logic [31:0]    y;
    logic [31:0]    z;
    logic [7:0]     idx;
    logic           fresh;
    logic [8:0]     count;
  } mesh_result_t;

  typedef enum {VM_ZERO, VM_ONES, VM_SIGNZ, VM_POOL, VM_UNIQUE, VM_STORED, VM_FILL,
                VM_RANDOM} vtx_mode_t;

  typedef struct {
    bit          sof;
    logic [31:0] count;
    int          nfaces;
    int          cut;
    int          junk;
    vtx_mode_t   mode;
    int          typed_done;
  } file_row_t;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_ready;
  logic [7:0]  data_byte;
  logic        start_of_file;
  logic        result_valid;
  logic        result_ready;
  logic [1:0]  kind;
  logic [31:0] coord_x;
  logic [31:0] coord_y;
  logic [31:0] coord_z;
  logic [7:0]  vertex_index;
  logic        is_new;
  logic [8:0]  vertex_count;

  stl_binary_mesh_indexer_top dut (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_ready(byte_ready),
    .data_byte(data_byte), .start_of_file(start_of_file),
    .result_valid(result_valid), .result_ready(result_ready),
    .kind(kind), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .vertex_index(vertex_index), .is_new(is_new), .vertex_count(vertex_count)
  );

  // parser mirror
  int unsigned      sec_pos;
  smi_pkg::phase_t  parse_phase;
  logic [31:0]      faces_left;
  logic [95:0]      gather;
  logic [95:0]      vtx_store [smi_pkg::VTX_CAP];
  int unsigned      vtx_stored;

  mesh_result_t pending_results[$];
  mesh_result_t want;
  int           errors;
  int           bytes_sent;
  int           file_left;
  int           fill_made;
  int           typed_done;
  logic [31:0]  uniq_ctr;
  logic [95:0]  pool [8];
  bit           idle_on;

  file_row_t dir_rows [12] = '{
    // no start mark after reset, zero faces, trailing bytes ignored
    '{1'b0, 32'd0,          0,   0, 3, VM_ZERO,   0},
    '{1'b1, 32'd1,          1,   0, 0, VM_ZERO,   1},
    // all-ones nan pattern must match itself
    '{1'b1, 32'd1,          1,   0, 2, VM_ONES,   1},
    '{1'b1, 32'd3,          3,   0, 0, VM_SIGNZ, -1},
    // huge count, file abandoned after two faces by the next start mark
    '{1'b1, 32'hFFFF_FFFF,  2,   0, 0, VM_POOL,  -1},
    '{1'b1, 32'd2,          2,  40, 0, VM_RANDOM, -1},
    '{1'b1, 32'h0100_0000,  0,  82, 0, VM_RANDOM, -1},
    '{1'b1, 32'h0001_0100,  1, 114, 0, VM_POOL,  -1},
    // one face more than counted: the extra one is ignored
    '{1'b1, 32'd2,          3,   0, 0, VM_RANDOM, -1},
    '{1'b1, 32'd3,          3,   0, 1, VM_UNIQUE, -1},
    // fill the table, overflow it, then hit stored entries
    '{1'b1, 32'd90,        90,   0, 0, VM_FILL,  256},
    '{1'b1, 32'd0,          0,   0, 0, VM_ZERO,   0}
  };

  task automatic parse_byte(input logic [7:0] b, input bit sof);
    mesh_result_t r;
    bit           got;
    int           hit;
    int unsigned  i;
    r = '0;
    got = 0;
    if (sof) begin
      sec_pos = 0;
      parse_phase = smi_pkg::PH_HEADER;
      faces_left = '0;
      gather = '0;
      vtx_stored = 0;
    end
    case (parse_phase)
      smi_pkg::PH_HEADER: begin
        sec_pos++;
        if (sec_pos >= smi_pkg::HEADER_BYTES) begin
          sec_pos = 0;
          parse_phase = smi_pkg::PH_COUNT;
          faces_left = '0;
        end
      end
      smi_pkg::PH_COUNT: begin
        faces_left[8*(sec_pos%4) +: 8] = b;
        sec_pos++;
        if (sec_pos >= smi_pkg::COUNT_BYTES) begin
          sec_pos = 0;
          if (faces_left == 0) begin
            parse_phase = smi_pkg::PH_DONE;
            r.kind = smi_pkg::KIND_DONE;
            got = 1;
          end else begin
            parse_phase = smi_pkg::PH_FACES;
          end
        end
      end
      smi_pkg::PH_FACES: begin
        if (sec_pos < 48) begin
          gather[8*(sec_pos%12) +: 8] = b;
          if (sec_pos % 12 == 11) begin
            got = 1;
            r.x = gather[31:0];
            r.y = gather[63:32];
            r.z = gather[95:64];
            if (sec_pos == 11) begin
              r.kind = smi_pkg::KIND_NORMAL;
            end else begin
              hit = -1;
              for (i = 0; i < vtx_stored && hit < 0; i++)
                if (vtx_store[i] == gather) hit = i;
              if (hit >= 0) begin
                r.kind = smi_pkg::KIND_VERTEX;
                r.idx = 8'(hit);
              end else if (vtx_stored < smi_pkg::VTX_CAP) begin
                vtx_store[vtx_stored] = gather;
                r.kind = smi_pkg::KIND_VERTEX;
                r.idx = 8'(vtx_stored);
                r.fresh = 1'b1;
                vtx_stored++;
              end else begin
                r.kind = smi_pkg::KIND_DROPPED;
              end
            end
          end
        end else if (sec_pos == smi_pkg::FACE_BYTES - 1) begin
          faces_left--;
          if (faces_left == 0) begin
            parse_phase = smi_pkg::PH_DONE;
            r.kind = smi_pkg::KIND_DONE;
            got = 1;
          end
        end
        sec_pos = (sec_pos + 1 >= smi_pkg::FACE_BYTES) ? 0 : sec_pos + 1;
      end
      default: ;
    endcase
    if (got) begin
      r.count = 9'(vtx_stored);
      if (r.kind == smi_pkg::KIND_DONE && typed_done >= 0) r.count = 9'(typed_done);
      pending_results = {pending_results, r};
    end
  endtask

  // one byte transfer, with an optional idle burst ahead of it; entered and left at negedge
  task automatic feed(input logic [7:0] b, input bit sof);
    if (file_left == 0) return;
    file_left--;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      byte_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    byte_valid = 1'b1;
    data_byte = b;
    start_of_file = sof;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    parse_byte(b, sof);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [95:0] pick_vertex(input vtx_mode_t m);
    logic [95:0] v;
    vtx_mode_t   eff;
    eff = m;
    if (m == VM_FILL) begin
      eff = (fill_made < smi_pkg::VTX_CAP + 2) ? VM_UNIQUE : VM_STORED;
      fill_made++;
    end
    case (eff)
      VM_ZERO:  v = '0;
      VM_ONES:  v = '1;
      VM_SIGNZ: v = {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h0,
                     $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0,
                     $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0};
      VM_POOL:  v = pool[$urandom_range(0, 7)];
      VM_UNIQUE: begin
        v = {uniq_ctr ^ 32'h3F80_0000, ~uniq_ctr, uniq_ctr};
        uniq_ctr++;
      end
      VM_STORED: begin
        if (vtx_stored == 0) v = {$urandom, $urandom, $urandom};
        else if ($urandom_range(0, 1) == 0) v = vtx_store[vtx_stored - 1];
        else v = vtx_store[$urandom_range(0, vtx_stored - 1)];
      end
      default:  v = {$urandom, $urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [7:0] fill_byte(input vtx_mode_t m);
    if (m == VM_ZERO) return 8'h00;
    if (m == VM_ONES) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_face(input vtx_mode_t m);
    logic [7:0]  fb [smi_pkg::FACE_BYTES];
    logic [95:0] v;
    int          j;
    int          n;
    for (j = 0; j < 12; j++) fb[j] = fill_byte(m);
    for (n = 1; n < 4; n++) begin
      v = pick_vertex(m);
      for (j = 0; j < 12; j++) fb[12*n + j] = v[8*j +: 8];
    end
    fb[48] = fill_byte(m);
    fb[49] = fill_byte(m);
    for (j = 0; j < smi_pkg::FACE_BYTES; j++) feed(fb[j], 1'b0);
  endtask

  task automatic send_file(input file_row_t row);
    int i;
    file_left = (row.cut != 0) ? row.cut : 32'h7FFF_FFFF;
    fill_made = 0;
    typed_done = row.typed_done;
    for (i = 0; i < smi_pkg::HEADER_BYTES; i++) feed(fill_byte(row.mode), row.sof && i == 0);
    for (i = 0; i < smi_pkg::COUNT_BYTES; i++) feed(row.count[8*i +: 8], 1'b0);
    for (i = 0; i < row.nfaces; i++) send_face(row.mode);
    file_left = 32'h7FFF_FFFF;
    for (i = 0; i < row.junk; i++) feed(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: ready drops in random bursts while idling is on
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        result_ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      result_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: kind %0d", kind);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind));
        check_field("coord_x", want.x, coord_x);
        check_field("coord_y", want.y, coord_y);
        check_field("coord_z", want.z, coord_z);
        check_field("vertex_index", 32'(want.idx), 32'(vertex_index));
        check_field("is_new", 32'(want.fresh), 32'(is_new));
        check_field("vertex_count", 32'(want.count), 32'(vertex_count));
      end
    end
  end

  initial begin
    file_row_t row;
    int        rand_bytes;
    int        r;
    rst = 1'b1;
    byte_valid = 1'b0;
    data_byte = '0;
    start_of_file = 1'b0;
    errors = 0;
    bytes_sent = 0;
    typed_done = -1;
    uniq_ctr = 32'h0;
    idle_on = 1'b1;
    sec_pos = 0;
    parse_phase = smi_pkg::PH_HEADER;
    faces_left = '0;
    gather = '0;
    vtx_stored = 0;
    pool[0] = '0;
    pool[1] = {64'h0, 32'h8000_0000};
    pool[2] = {3{32'h8000_0000}};
    pool[3] = '1;
    for (r = 4; r < 8; r++) pool[r] = {$urandom, $urandom, $urandom};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (r = 0; r < 12; r++) send_file(dir_rows[r]);

    // random files: mostly well formed with small counts, some cut short or padded
    rand_bytes = bytes_sent;
    while (bytes_sent - rand_bytes < 650) begin
      if (bytes_sent - rand_bytes >= 550) idle_on = 1'b0;
      row.sof = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 9))
        0:       row.count = 32'd0;
        1:       row.count = $urandom;
        default: row.count = $urandom_range(1, 3);
      endcase
      row.nfaces = (row.count > 3) ? $urandom_range(0, 2)
                                   : row.count + ($urandom_range(0, 5) == 0);
      row.cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 84 + 50 * row.nfaces) : 0;
      row.junk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      case ($urandom_range(0, 7))
        0:       row.mode = VM_RANDOM;
        1:       row.mode = VM_SIGNZ;
        2, 3, 4: row.mode = VM_POOL;
        default: row.mode = VM_STORED;
      endcase
      row.typed_done = -1;
      send_file(row);
    end
    idle_on = 1'b0;
    byte_valid = 1'b0;
    start_of_file = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
